@@ rtl/core/orot_pkg.sv @@
package orot_pkg;

  // Width of every coordinate field at the ports.
  localparam int FIELD_W = 32;

  // Edge vectors per pair: the down and right edge of each rectangle. Each one is also a test axis.
  localparam int NUM_EDGES = 4;
  localparam int NUM_AXES  = 4;

  // Register stages inside one lane: products, dots, magnitudes, half sums, compare.
  localparam int LANE_DEPTH = 5;

  // One input beat as it arrives at the ports, before sign extension.
  typedef struct packed {
    logic [FIELD_W-1:0] c1x;
    logic [FIELD_W-1:0] c1y;
    logic [FIELD_W-1:0] d1x;
    logic [FIELD_W-1:0] d1y;
    logic [FIELD_W-1:0] r1x;
    logic [FIELD_W-1:0] r1y;
    logic [FIELD_W-1:0] c2x;
    logic [FIELD_W-1:0] c2y;
    logic [FIELD_W-1:0] d2x;
    logic [FIELD_W-1:0] d2y;
    logic [FIELD_W-1:0] r2x;
    logic [FIELD_W-1:0] r2y;
  } pair_beat_t;

endpackage

@@ rtl/core/orot_lane.sv @@
module orot_lane
  import orot_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS:0]   dx,
  input  logic signed [COORD_BITS:0]   dy,
  input  logic signed [COORD_BITS-1:0] ex [NUM_EDGES],
  input  logic signed [COORD_BITS-1:0] ey [NUM_EDGES],
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  output logic                         sep
);

  localparam int W  = COORD_BITS;
  localparam int DW = 2 * W + 1;
  localparam int EW = 2 * W;
  localparam int PW = 2 * W + 3;

  logic signed [DW-1:0] pd_x;
  logic signed [DW-1:0] pd_y;
  logic signed [EW-1:0] pe_x [NUM_EDGES];
  logic signed [EW-1:0] pe_y [NUM_EDGES];
  logic signed [PW-1:0] dot_d;
  logic signed [PW-1:0] dot_e [NUM_EDGES];
  logic        [PW-1:0] abs_d;
  logic        [PW-1:0] abs_e [NUM_EDGES];
  logic        [PW-1:0] lhs;
  logic        [PW-1:0] lhs_d;
  logic        [PW-1:0] mag_e [NUM_EDGES];
  logic        [PW-1:0] half0;
  logic        [PW-1:0] half1;
  logic        [PW-1:0] rhs;

  // Magnitudes; the dot products never reach the top bit, so negation is exact.
  always_comb begin
    abs_d = dot_d[PW-1] ? PW'(-dot_d) : PW'(dot_d);
    for (int j = 0; j < NUM_EDGES; j++) begin
      abs_e[j] = dot_e[j][PW-1] ? PW'(-dot_e[j]) : PW'(dot_e[j]);
    end
  end

  assign rhs = half0 + half1;

  always_ff @(posedge clk) begin
    if (en) begin
      pd_x <= DW'(dx) * DW'(ax);
      pd_y <= DW'(dy) * DW'(ay);
      for (int j = 0; j < NUM_EDGES; j++) begin
        pe_x[j]  <= EW'(ex[j]) * EW'(ax);
        pe_y[j]  <= EW'(ey[j]) * EW'(ay);
        dot_e[j] <= PW'(pe_x[j]) + PW'(pe_y[j]);
        mag_e[j] <= abs_e[j];
      end
      dot_d <= PW'(pd_x) + PW'(pd_y);
      lhs   <= {abs_d[PW-2:0], 1'b0};
      lhs_d <= lhs;
      half0 <= mag_e[0] + mag_e[1];
      half1 <= mag_e[2] + mag_e[3];
      sep   <= lhs_d > rhs;
    end
  end

endmodule

@@ rtl/core/orot_merge.sv @@
module orot_merge
  import orot_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [NUM_AXES-1:0] sep,
  output logic                out_valid,
  output logic                overlap
);

  // The pair overlaps only when none of the lanes found a separating axis.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      overlap <= ~|sep;
    end
  end

endmodule

@@ rtl/core/oriented_rect_overlap_test.sv @@
// Path: stage one, the four axis lanes, then the merge register on out_valid. A beat that
// arrives during a stall waits in the skid register first, and a stall holds every stage.
// Throughput: one beat per cycle unless stalled; lanes and merge register are fully pipelined.
// Reset: synchronous active-high rst clears the skid flag, every stage valid and out_valid;
// the datapath registers carry no reset.
module oriented_rect_overlap_test
  import orot_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [FIELD_W-1:0] first_center_x,
  input  logic signed [FIELD_W-1:0] first_center_y,
  input  logic signed [FIELD_W-1:0] first_down_edge_x,
  input  logic signed [FIELD_W-1:0] first_down_edge_y,
  input  logic signed [FIELD_W-1:0] first_right_edge_x,
  input  logic signed [FIELD_W-1:0] first_right_edge_y,
  input  logic signed [FIELD_W-1:0] second_center_x,
  input  logic signed [FIELD_W-1:0] second_center_y,
  input  logic signed [FIELD_W-1:0] second_down_edge_x,
  input  logic signed [FIELD_W-1:0] second_down_edge_y,
  input  logic signed [FIELD_W-1:0] second_right_edge_x,
  input  logic signed [FIELD_W-1:0] second_right_edge_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      overlap
);

  localparam int W = COORD_BITS;

  // The whole pipeline moves as one. It advances whenever the output register is empty
  // or its beat is being taken this cycle.
  logic en;

  // Input skid register. It catches a beat that arrives during a stall, so that in_ready
  // comes from a flop and never from out_ready.
  logic       skid_full;
  pair_beat_t skid;
  pair_beat_t port_beat;
  pair_beat_t src;
  logic       in_acc;

  // Stage one: the edges, read as signed, and the centre difference.
  logic signed [W-1:0] s1_ex [NUM_EDGES];
  logic signed [W-1:0] s1_ey [NUM_EDGES];
  logic signed [W:0]   s1_dx;
  logic signed [W:0]   s1_dy;
  logic signed [W-1:0] c1x;
  logic signed [W-1:0] c1y;
  logic signed [W-1:0] c2x;
  logic signed [W-1:0] c2y;

  // Valid bit for stage one and for each lane stage.
  logic [LANE_DEPTH:0] vld;
  logic [NUM_AXES-1:0] sep;

  assign en       = !out_valid || out_ready;
  assign in_ready = !skid_full;
  assign in_acc   = in_valid && in_ready;

  assign port_beat = '{
    c1x: first_center_x,      c1y: first_center_y,
    d1x: first_down_edge_x,   d1y: first_down_edge_y,
    r1x: first_right_edge_x,  r1y: first_right_edge_y,
    c2x: second_center_x,     c2y: second_center_y,
    d2x: second_down_edge_x,  d2y: second_down_edge_y,
    r2x: second_right_edge_x, r2y: second_right_edge_y
  };

  // A waiting beat in the skid register always goes first.
  assign src = skid_full ? skid : port_beat;

  // Only the low COORD_BITS bits of each field count; they are read as signed.
  assign c1x = signed'(src.c1x[W-1:0]);
  assign c1y = signed'(src.c1y[W-1:0]);
  assign c2x = signed'(src.c2x[W-1:0]);
  assign c2y = signed'(src.c2y[W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
      vld       <= '0;
    end else if (en) begin
      // Either the skid beat drains, or a fresh beat passes straight into stage one.
      skid_full <= 1'b0;
      vld       <= {vld[LANE_DEPTH-1:0], skid_full || in_acc};
    end else if (in_acc) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_acc) begin
      skid <= port_beat;
    end
  end

  // Edge order: first down, first right, second down, second right.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_ex[0] <= signed'(src.d1x[W-1:0]);
      s1_ey[0] <= signed'(src.d1y[W-1:0]);
      s1_ex[1] <= signed'(src.r1x[W-1:0]);
      s1_ey[1] <= signed'(src.r1y[W-1:0]);
      s1_ex[2] <= signed'(src.d2x[W-1:0]);
      s1_ey[2] <= signed'(src.d2y[W-1:0]);
      s1_ex[3] <= signed'(src.r2x[W-1:0]);
      s1_ey[3] <= signed'(src.r2y[W-1:0]);
      s1_dx    <= (W+1)'(c2x) - (W+1)'(c1x);
      s1_dy    <= (W+1)'(c2y) - (W+1)'(c1y);
    end
  end

  // One lane for each edge taken as an axis. Each lane compares twice the projected centre
  // difference with the sum of all four projected edges, both scaled by the axis length,
  // so that no square root or division is needed. A zero edge gives zero on both sides
  // and never separates; equal sides do not separate either, so touching pairs overlap.
  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    orot_lane #(
      .COORD_BITS(COORD_BITS)
    ) u_lane (
      .clk (clk),
      .en  (en),
      .dx  (s1_dx),
      .dy  (s1_dy),
      .ex  (s1_ex),
      .ey  (s1_ey),
      .ax  (s1_ex[i]),
      .ay  (s1_ey[i]),
      .sep (sep[i])
    );
  end

  // The merge stage reduces the four verdicts and holds the result beat for the consumer.
  orot_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vld[LANE_DEPTH]),
    .sep       (sep),
    .out_valid (out_valid),
    .overlap   (overlap)
  );

  // A beat held in the skid register leaves it as soon as the pipeline moves.
  a_skid_drains : assert property (@(posedge clk) disable iff (rst)
    skid_full && en |=> !skid_full)
    else $error("skid register did not drain on an advancing cycle");

  // A beat accepted during a stall must be captured by the skid register.
  a_skid_catches : assert property (@(posedge clk) disable iff (rst)
    in_acc && !en |=> skid_full)
    else $error("beat accepted during a stall was not captured");

  // While stalled, no stage may gain or lose a beat.
  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld) && $stable(out_valid))
    else $error("pipeline valids changed during a stall");

  // A beat at the last lane stage reaches the output register when the pipeline moves.
  a_last_to_out : assert property (@(posedge clk) disable iff (rst)
    en && vld[LANE_DEPTH] |=> out_valid)
    else $error("beat lost between the lanes and the output register");

endmodule
